// ----- rtl/rtaa_pkg.sv -----
// shared types and constants for the region triangle area accumulator
// used by every module in rtl/, no dependencies of its own
`default_nettype none

package rtaa_pkg;

  localparam int TAG_W   = 16;
  localparam int COORD_W = 16;
  localparam int AREA_W  = 47;
  localparam int SUM_W   = 28;
  localparam int CNT_W   = 13;
  localparam int RAD_W   = 16;

  localparam int MAX_REGION_POINTS = 4096;
  localparam int COUNT_CAP         = 8191;
  localparam int POINT_LIMIT = (MAX_REGION_POINTS < COUNT_CAP) ? MAX_REGION_POINTS : COUNT_CAP;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one classified point handed from the front to the back
  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      stream_end;
    logic                      close_run;
    logic                      new_run;
  } rtaa_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rtaa_qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESET,
    ST_ADD,
    ST_DET0,
    ST_DET1,
    ST_DET2,
    ST_ACCUM,
    ST_SQ_X,
    ST_SQ_Y,
    ST_RAD,
    ST_RAD_SQ,
    ST_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/rtaa_fifo.sv -----
// short command queue between the front and the back
// uses rtaa_pkg for the command type and depth
`default_nettype none

module rtaa_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rtaa_pkg::rtaa_cmd_t push_cmd_i,
  input  wire logic               pop_i,
  output rtaa_pkg::rtaa_cmd_t     pop_cmd_o,
  output rtaa_pkg::rtaa_qstat_t   stat_o
);

  rtaa_pkg::rtaa_cmd_t              mem_q [rtaa_pkg::QUEUE_DEPTH];
  logic [rtaa_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rtaa_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [rtaa_pkg::QUEUE_AW:0]      cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (rtaa_pkg::QUEUE_AW+1)'(rtaa_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- rtl/rtaa_front.sv -----
// input side: accepts points and marks run boundaries
// uses rtaa_pkg, feeds rtaa_fifo
`default_nettype none

module rtaa_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [rtaa_pkg::TAG_W-1:0] in_tag_i,
  input  wire logic [rtaa_pkg::COORD_W-1:0] in_x_i,
  input  wire logic [rtaa_pkg::COORD_W-1:0] in_y_i,
  input  wire logic                       in_end_i,
  input  wire rtaa_pkg::rtaa_qstat_t      qstat_i,
  output logic                            push_o,
  output rtaa_pkg::rtaa_cmd_t             push_cmd_o
);

  logic                       open_q, open_d;
  logic [rtaa_pkg::TAG_W-1:0] open_tag_q, open_tag_d;
  logic                       tag_change;

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && in_ready_o;
  assign tag_change = open_q && (in_tag_i != open_tag_q);

  always_comb begin
    push_cmd_o.tag        = in_tag_i;
    push_cmd_o.x          = in_x_i;
    push_cmd_o.y          = in_y_i;
    push_cmd_o.stream_end = in_end_i;
    push_cmd_o.close_run  = tag_change;
    push_cmd_o.new_run    = tag_change || !open_q;
  end

  always_comb begin
    open_d     = open_q;
    open_tag_d = open_tag_q;
    if (push_o) begin
      // a stream end closes the run, the next point opens a new one
      open_d     = !in_end_i;
      open_tag_d = in_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      open_tag_q <= '0;
    end else begin
      open_q     <= open_d;
      open_tag_q <= open_tag_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rtaa_back.sv -----
// back side: accumulates area and coordinate sums, runs the centroid test
// and holds the result register; uses rtaa_pkg, reads from rtaa_fifo
`default_nettype none

module rtaa_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [rtaa_pkg::RAD_W-1:0]  radius_i,
  input  wire rtaa_pkg::rtaa_qstat_t       qstat_i,
  input  wire rtaa_pkg::rtaa_cmd_t         cmd_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rtaa_pkg::TAG_W-1:0]       out_region_o,
  output logic [rtaa_pkg::AREA_W-1:0]      out_area_o,
  output logic                             out_outside_o,
  output logic                             out_ovf_o,
  output logic                             out_last_o
);

  localparam int SUM_EXT_W = rtaa_pkg::SUM_W + 1;
  localparam int DIFF_W    = rtaa_pkg::COORD_W + 1;
  localparam int DPROD_W   = rtaa_pkg::COORD_W + DIFF_W;
  localparam int DET_W     = DPROD_W + 2;
  localparam int EM_W      = rtaa_pkg::RAD_W + rtaa_pkg::CNT_W;
  localparam int EP_W      = 2 * EM_W;
  localparam int LHS_W     = 2 * rtaa_pkg::SUM_W;

  rtaa_pkg::back_state_e state_q, state_d;

  rtaa_pkg::rtaa_cmd_t              cmd_q;
  logic                             end_emit_q;
  logic [rtaa_pkg::TAG_W-1:0]       run_tag_q;
  logic [1:0]                       phase_q;
  logic signed [rtaa_pkg::COORD_W-1:0] hx0_q, hy0_q, hx1_q, hy1_q;
  logic [rtaa_pkg::AREA_W-1:0]      area_q;
  logic signed [rtaa_pkg::SUM_W-1:0] sumx_q, sumy_q;
  logic signed [rtaa_pkg::SUM_W-1:0] sumx_sat, sumy_sat;
  logic                             sumx_ovf, sumy_ovf;
  logic [rtaa_pkg::CNT_W-1:0]       cnt_q;
  logic                             ovf_q;
  logic signed [DET_W-1:0]          det_q;
  logic [LHS_W-1:0]                 lhs_q;
  logic [EP_W-1:0]                  prod_q;

  logic                             at_limit;
  logic                             pop;
  logic                             out_load;
  logic signed [SUM_EXT_W-1:0]      sumx_ext, sumy_ext;
  logic signed [rtaa_pkg::COORD_W-1:0] dm_a;
  logic signed [DIFF_W-1:0]         dm_b;
  logic signed [DPROD_W-1:0]        dm_p;
  logic [EM_W-1:0]                  em_a, em_b;
  logic [EP_W-1:0]                  em_p;
  logic [rtaa_pkg::SUM_W-1:0]       sx_mag, sy_mag;
  logic [DET_W-1:0]                 det_abs;
  logic [rtaa_pkg::AREA_W:0]        area_ext;
  logic                             in_circle;

  assign at_limit = (cnt_q >= rtaa_pkg::CNT_W'(rtaa_pkg::POINT_LIMIT));

  // saturating coordinate sums
  assign sumx_ext = {sumx_q[rtaa_pkg::SUM_W-1], sumx_q} + SUM_EXT_W'(cmd_q.x);
  assign sumy_ext = {sumy_q[rtaa_pkg::SUM_W-1], sumy_q} + SUM_EXT_W'(cmd_q.y);
  assign sumx_ovf = sumx_ext[SUM_EXT_W-1] != sumx_ext[SUM_EXT_W-2];
  assign sumy_ovf = sumy_ext[SUM_EXT_W-1] != sumy_ext[SUM_EXT_W-2];

  always_comb begin
    sumx_sat = sumx_ext[rtaa_pkg::SUM_W-1:0];
    sumy_sat = sumy_ext[rtaa_pkg::SUM_W-1:0];
    if (sumx_ovf) begin
      sumx_sat = {sumx_ext[SUM_EXT_W-1], {(rtaa_pkg::SUM_W-1){!sumx_ext[SUM_EXT_W-1]}}};
    end
    if (sumy_ovf) begin
      sumy_sat = {sumy_ext[SUM_EXT_W-1], {(rtaa_pkg::SUM_W-1){!sumy_ext[SUM_EXT_W-1]}}};
    end
  end

  assign dm_p      = dm_a * dm_b;
  assign em_p      = em_a * em_b;
  assign sx_mag    = sumx_q[rtaa_pkg::SUM_W-1] ? (~sumx_q + 1'b1) : sumx_q;
  assign sy_mag    = sumy_q[rtaa_pkg::SUM_W-1] ? (~sumy_q + 1'b1) : sumy_q;
  assign det_abs   = det_q[DET_W-1] ? (~det_q + 1'b1) : det_q;
  assign area_ext  = {1'b0, area_q} + (rtaa_pkg::AREA_W+1)'(det_abs);
  assign in_circle = (cnt_q != '0) && ((EP_W)'(lhs_q) <= prod_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtaa_pkg::ST_IDLE: begin
        if (!qstat_i.empty) begin
          if (cmd_i.close_run) begin
            state_d = rtaa_pkg::ST_SQ_X;
          end else if (cmd_i.new_run) begin
            state_d = rtaa_pkg::ST_RESET;
          end else begin
            state_d = rtaa_pkg::ST_ADD;
          end
        end
      end
      rtaa_pkg::ST_RESET: state_d = rtaa_pkg::ST_ADD;
      rtaa_pkg::ST_ADD: begin
        if (!at_limit && phase_q == 2'd2) begin
          state_d = rtaa_pkg::ST_DET0;
        end else begin
          state_d = cmd_q.stream_end ? rtaa_pkg::ST_SQ_X : rtaa_pkg::ST_IDLE;
        end
      end
      rtaa_pkg::ST_DET0:   state_d = rtaa_pkg::ST_DET1;
      rtaa_pkg::ST_DET1:   state_d = rtaa_pkg::ST_DET2;
      rtaa_pkg::ST_DET2:   state_d = rtaa_pkg::ST_ACCUM;
      rtaa_pkg::ST_ACCUM:  state_d = cmd_q.stream_end ? rtaa_pkg::ST_SQ_X : rtaa_pkg::ST_IDLE;
      rtaa_pkg::ST_SQ_X:   state_d = rtaa_pkg::ST_SQ_Y;
      rtaa_pkg::ST_SQ_Y:   state_d = rtaa_pkg::ST_RAD;
      rtaa_pkg::ST_RAD:    state_d = rtaa_pkg::ST_RAD_SQ;
      rtaa_pkg::ST_RAD_SQ: state_d = rtaa_pkg::ST_OUT;
      rtaa_pkg::ST_OUT: begin
        // a run closed by a tag change is followed by the new run's point
        if (out_load) begin
          state_d = end_emit_q ? rtaa_pkg::ST_IDLE : rtaa_pkg::ST_RESET;
        end
      end
      default: state_d = rtaa_pkg::ST_IDLE;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    dm_a     = cmd_q.x;
    dm_b     = DIFF_W'(hy0_q) - DIFF_W'(hy1_q);
    em_a     = EM_W'(sx_mag);
    em_b     = EM_W'(sx_mag);
    unique case (state_q)
      rtaa_pkg::ST_IDLE: pop = !qstat_i.empty;
      rtaa_pkg::ST_DET0: begin
        dm_a = hx0_q;
        dm_b = DIFF_W'(hy1_q) - DIFF_W'(cmd_q.y);
      end
      rtaa_pkg::ST_DET1: begin
        dm_a = hx1_q;
        dm_b = DIFF_W'(cmd_q.y) - DIFF_W'(hy0_q);
      end
      rtaa_pkg::ST_SQ_Y: begin
        em_a = EM_W'(sy_mag);
        em_b = EM_W'(sy_mag);
      end
      rtaa_pkg::ST_RAD: begin
        em_a = EM_W'(radius_i);
        em_b = EM_W'(cnt_q);
      end
      rtaa_pkg::ST_RAD_SQ: begin
        em_a = prod_q[EM_W-1:0];
        em_b = prod_q[EM_W-1:0];
      end
      rtaa_pkg::ST_OUT: out_load = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtaa_pkg::ST_IDLE;
      end_emit_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        end_emit_q <= 1'b0;
      end else if (state_q == rtaa_pkg::ST_ADD || state_q == rtaa_pkg::ST_ACCUM) begin
        end_emit_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // run accumulators, cleared by the reset step at the start of every run
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
    end
    unique case (state_q)
      rtaa_pkg::ST_RESET: begin
        run_tag_q <= cmd_q.tag;
        phase_q   <= 2'd0;
        area_q    <= '0;
        sumx_q    <= '0;
        sumy_q    <= '0;
        cnt_q     <= '0;
        ovf_q     <= 1'b0;
      end
      rtaa_pkg::ST_ADD: begin
        if (at_limit) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q  <= cnt_q + 1'b1;
          sumx_q <= sumx_sat;
          sumy_q <= sumy_sat;
          if (sumx_ovf || sumy_ovf) begin
            ovf_q <= 1'b1;
          end
          if (phase_q == 2'd0) begin
            hx0_q   <= cmd_q.x;
            hy0_q   <= cmd_q.y;
            phase_q <= 2'd1;
          end else if (phase_q == 2'd1) begin
            hx1_q   <= cmd_q.x;
            hy1_q   <= cmd_q.y;
            phase_q <= 2'd2;
          end
        end
      end
      rtaa_pkg::ST_DET0: det_q <= DET_W'(dm_p);
      rtaa_pkg::ST_DET1: det_q <= det_q + DET_W'(dm_p);
      rtaa_pkg::ST_DET2: det_q <= det_q + DET_W'(dm_p);
      rtaa_pkg::ST_ACCUM: begin
        phase_q <= 2'd0;
        if (area_ext[rtaa_pkg::AREA_W]) begin
          area_q <= '1;
          ovf_q  <= 1'b1;
        end else begin
          area_q <= area_ext[rtaa_pkg::AREA_W-1:0];
        end
      end
      rtaa_pkg::ST_SQ_X: prod_q <= em_p;
      rtaa_pkg::ST_SQ_Y: begin
        lhs_q  <= prod_q[LHS_W-1:0];
        prod_q <= em_p;
      end
      rtaa_pkg::ST_RAD: begin
        lhs_q  <= lhs_q + prod_q[LHS_W-1:0];
        prod_q <= em_p;
      end
      rtaa_pkg::ST_RAD_SQ: prod_q <= em_p;
      default: ;
    endcase
    if (out_load) begin
      out_region_o  <= run_tag_q;
      out_area_o    <= in_circle ? area_q : '0;
      out_outside_o <= !in_circle;
      out_ovf_o     <= ovf_q;
      out_last_o    <= end_emit_q || !cmd_q.stream_end;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/region_triangle_area_accumulator_core.sv -----
// Region triangle area accumulator, top level.
// Points enter on the s_axis channel: tdata holds region tag, x and y (signed
// Q8.8), tlast marks the last point of the stream. Consecutive points with one
// tag form a run; each group of three points adds its doubled shoelace area.
// One result leaves on m_axis when the tag changes (before the new point is
// counted) and one after a point with tlast, so a point gives zero, one or two
// results; m_axis_tlast marks the last result caused by a point.
// The radius register is written through cfg_valid_i/cfg_data_i, taken at once;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Reset clears the control state and the radius.
// A point passes the back end idle and add steps when it opens no triangle,
// also DET0 to DET2 and the accumulate step when it closes one, plus a reset
// step for a run start; each result adds the centroid test steps, on a shared
// 29x29 multiplier, and the output step. The front end takes one point per
// cycle into a 4-entry queue until it fills, so the sustained rate is set by
// the back end sequencer, which takes a new point only once it is done with
// the last one.
// When m_axis_tready is low the result register holds, the back end waits in
// its output step and the queue fills, after which s_axis_tready drops.
// Dependencies: rtaa_pkg, rtaa_front, rtaa_fifo, rtaa_back.
`default_nettype none

module region_triangle_area_accumulator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,     // domain_radius
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // region_tag, coord_x, coord_y
  input  wire logic        s_axis_tlast,   // stream_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // result_region, area_value, zero pad
  output logic [1:0]       m_axis_tuser,   // outside_circle, overflowed
  output logic             m_axis_tlast    // last_of_run
);

  logic [rtaa_pkg::RAD_W-1:0]  radius_q;
  logic                        push;
  logic                        pop;
  rtaa_pkg::rtaa_cmd_t         push_cmd;
  rtaa_pkg::rtaa_cmd_t         pop_cmd;
  rtaa_pkg::rtaa_qstat_t       qstat;
  logic [rtaa_pkg::TAG_W-1:0]  out_region;
  logic [rtaa_pkg::AREA_W-1:0] out_area;
  logic                        out_outside;
  logic                        out_ovf;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  rtaa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_tag_i   (s_axis_tdata[15:0]),
    .in_x_i     (s_axis_tdata[31:16]),
    .in_y_i     (s_axis_tdata[47:32]),
    .in_end_i   (s_axis_tlast),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  rtaa_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .stat_o     (qstat)
  );

  rtaa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radius_i      (radius_q),
    .qstat_i       (qstat),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_region_o  (out_region),
    .out_area_o    (out_area),
    .out_outside_o (out_outside),
    .out_ovf_o     (out_ovf),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_area, out_region};
  assign m_axis_tuser = {out_ovf, out_outside};

  // queue never written while full or read while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("command queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !qstat.empty)
    else $error("command queue read while empty");

  // an outside result never reports a nonzero area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[62:16] == '0))
    else $error("outside result carries an area");

endmodule

`default_nettype wire
